FILE: rtl/core/hvdc_pkg.sv
// shared types and constants for the hblank video-ram dma controller
package hvdc_pkg;

   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;
   localparam logic [1:0] OP_NOP   = 2'd3;

   localparam logic [2:0] REG_SRC_HI = 3'd0;
   localparam logic [2:0] REG_SRC_LO = 3'd1;
   localparam logic [2:0] REG_DST_HI = 3'd2;
   localparam logic [2:0] REG_DST_LO = 3'd3;
   localparam logic [2:0] REG_CTRL   = 3'd4;

   localparam logic [2:0] ST_NONE         = 3'd0;
   localparam logic [2:0] ST_PAUSED       = 3'd1;
   localparam logic [2:0] ST_REQUESTED    = 3'd2;
   localparam logic [2:0] ST_PENDING      = 3'd3;
   localparam logic [2:0] ST_READY        = 3'd4;
   localparam logic [2:0] ST_TRANSFERRING = 3'd5;

   localparam logic [1:0] UNBLOCK_DELAY = 2'd2;

   localparam logic [7:0] SRC_HI_RST = 8'hD4;
   localparam logic [7:0] SRC_LO_RST = 8'h30;
   localparam logic [7:0] DST_HI_RST = 8'h99;
   localparam logic [7:0] DST_LO_RST = 8'hD0;
   localparam logic [7:0] CHUNKS_RST = 8'hFF;

   typedef struct packed {
      logic [1:0]  op;
      logic [2:0]  reg_index;
      logic [7:0]  write_value;
      logic [1:0]  cycle_phase;
      logic [1:0]  ppu_mode;
      logic        cpu_halted;
      logic        cpu_stopped;
      logic        cpu_fetching;
      logic        double_speed;
      logic        oam_held_by_dma;
      logic [7:0]  source_data;
   } item_type;

   typedef struct packed {
      logic [7:0]  read_value;
      logic        src_read_en;
      logic [15:0] src_address;
      logic        vram_write_en;
      logic [15:0] vram_address;
      logic        oam_write_en;
      logic [15:0] oam_address;
      logic [7:0]  write_data;
      logic        cpu_blocked;
      logic        buses_held;
   } result_type;

endpackage

FILE: rtl/core/hvdc_engine.sv
// transfer engine state and one-step update per item
module hvdc_engine (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  hvdc_pkg::item_type    item,
   output hvdc_pkg::result_type  result
);
   import hvdc_pkg::*;

   logic [7:0]  src_hi_ff, src_hi_in, src_lo_ff, src_lo_in;
   logic [7:0]  dst_hi_ff, dst_hi_in, dst_lo_ff, dst_lo_in;
   logic [15:0] src_off_ff, src_off_in, dst_off_ff, dst_off_in;
   logic        src_ok_ff, src_ok_in;
   logic [11:0] bytes_ff, bytes_in;
   logic [7:0]  chunks_ff, chunks_in;
   logic        due_ff, due_in;
   logic [2:0]  state_ff, state_in;
   logic        hb_ff, hb_in;
   logic [1:0]  unblk_ff, unblk_in;
   logic [1:0]  pmode_ff, pmode_in;
   logic        phalt_ff, phalt_in;
   logic        busy_ff, busy_in;
   logic        conf_ff, conf_in;
   logic [15:0] pvaddr_ff, pvaddr_in;
   logic [7:0]  poam_ff, poam_in;
   logic        own_ff, own_in;

   logic [15:0] sa, da, dend;
   logic        even;

   assign sa   = {src_hi_ff, src_lo_ff} + src_off_ff;
   assign da   = {1'b1, dst_hi_ff[6:0], dst_lo_ff} + dst_off_ff;
   assign even = ~item.cycle_phase[0];

   always_comb begin
      logic [2:0] st;
      src_hi_in = src_hi_ff; src_lo_in = src_lo_ff;
      dst_hi_in = dst_hi_ff; dst_lo_in = dst_lo_ff;
      src_off_in = src_off_ff; dst_off_in = dst_off_ff;
      src_ok_in = src_ok_ff; bytes_in = bytes_ff; chunks_in = chunks_ff;
      due_in = due_ff; state_in = state_ff; hb_in = hb_ff; unblk_in = unblk_ff;
      pmode_in = pmode_ff; phalt_in = phalt_ff; busy_in = busy_ff;
      conf_in = conf_ff; pvaddr_in = pvaddr_ff; poam_in = poam_ff; own_in = own_ff;
      dend = 16'd0;
      st = ST_NONE;
      result = '0;
      result.vram_address = 16'h8000;
      result.oam_address  = 16'hFE00;

      unique case (item.op)
         OP_WRITE: begin
            unique case (item.reg_index)
               REG_SRC_HI: src_hi_in = item.write_value;
               REG_SRC_LO: begin
                  src_lo_in = {item.write_value[7:4], 4'h0};
                  src_off_in = '0;
               end
               REG_DST_HI: dst_hi_in = item.write_value;
               REG_DST_LO: begin
                  dst_lo_in = {item.write_value[7:4], 4'h0};
                  dst_off_in = '0;
               end
               REG_CTRL: begin
                  chunks_in = {1'b0, item.write_value[6:0]};
                  bytes_in = {1'b0, item.write_value[6:0], 4'h0} + 12'd16;
                  if (state_ff != ST_NONE) begin
                     if (!item.write_value[7]) state_in = ST_NONE;
                  end else if (item.write_value[7]) begin
                     hb_in = 1'b1;
                     state_in = (item.ppu_mode == 2'd0) ? ST_REQUESTED : ST_PAUSED;
                  end else begin
                     hb_in = 1'b0;
                     state_in = ST_REQUESTED;
                  end
               end
               default: ;
            endcase
         end
         OP_READ: result.read_value = {(state_ff == ST_NONE), chunks_ff[6:0]};
         OP_TICK: begin
            st = state_ff;
            if (even) begin
               if (st == ST_TRANSFERRING) begin
                  src_ok_in = (sa < 16'h8000) || (sa >= 16'hA000 && sa <= 16'hDFFF);
                  result.src_read_en = src_ok_in;
                  result.src_address = sa;
                  conf_in = item.oam_held_by_dma & src_off_ff[0];
                  poam_in = sa[7:0];
                  pvaddr_in = {3'b100, da[12:0]};
               end
            end else if (st == ST_TRANSFERRING) begin
               result.vram_write_en = 1'b1;
               result.vram_address = pvaddr_ff;
               result.write_data = item.source_data;
               if (conf_ff) begin
                  result.oam_write_en = 1'b1;
                  result.oam_address = {8'hFE, poam_ff};
               end
               src_off_in = src_off_ff + 16'd1;
               dst_off_in = dst_off_ff + 16'd1;
               bytes_in = bytes_ff - 12'd1;
               if (bytes_in[3:0] == 4'h0) begin
                  if (bytes_in == 12'd0) st = ST_NONE;
                  else if (hb_ff) st = ST_PAUSED;
                  dend = da + 16'd1;
                  if (dend != 16'd0) begin
                     if (hb_ff || chunks_ff == 8'd0) unblk_in = UNBLOCK_DELAY;
                  end else begin
                     st = ST_NONE;
                     bytes_in = '0;
                     dst_hi_in = '0;
                     dst_lo_in = '0;
                     dst_off_in = '0;
                     unblk_in = UNBLOCK_DELAY;
                  end
                  if (st != ST_TRANSFERRING) own_in = 1'b0;
                  due_in = 1'b1;
               end
            end
            // hblank rising edge restarts a paused transfer
            if (st == ST_PAUSED && pmode_ff != 2'd0 && item.ppu_mode == 2'd0 &&
                !phalt_ff && !item.cpu_stopped)
               st = ST_REQUESTED;
            pmode_in = item.ppu_mode;
            phalt_in = item.cpu_halted;
            if (even) begin
               if (st == ST_REQUESTED) st = ST_PENDING;
               else if (st == ST_PENDING) st = ST_READY;
            end else if (item.cycle_phase == 2'd3 || item.double_speed) begin
               if (st == ST_READY) begin
                  if (item.cpu_fetching) begin
                     st = ST_TRANSFERRING;
                     busy_in = 1'b1;
                     own_in = 1'b1;
                  end
               end else if (due_in) begin
                  due_in = 1'b0;
                  chunks_in = chunks_ff - 8'd1;
               end else if (unblk_in != 2'd0) begin
                  unblk_in = unblk_in - 2'd1;
                  if (unblk_in == 2'd0) busy_in = 1'b0;
               end
            end
            state_in = st;
         end
         default: ;
      endcase
      result.cpu_blocked = busy_in;
      result.buses_held = own_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_hi_ff <= SRC_HI_RST; src_lo_ff <= SRC_LO_RST;
         dst_hi_ff <= DST_HI_RST; dst_lo_ff <= DST_LO_RST;
         src_off_ff <= '0; dst_off_ff <= '0; src_ok_ff <= 1'b0;
         bytes_ff <= '0; chunks_ff <= CHUNKS_RST; due_ff <= 1'b0;
         state_ff <= ST_NONE; hb_ff <= 1'b0; unblk_ff <= '0;
         pmode_ff <= '0; phalt_ff <= 1'b0; busy_ff <= 1'b0;
         conf_ff <= 1'b0; pvaddr_ff <= '0; poam_ff <= '0; own_ff <= 1'b0;
      end else if (step) begin
         src_hi_ff <= src_hi_in; src_lo_ff <= src_lo_in;
         dst_hi_ff <= dst_hi_in; dst_lo_ff <= dst_lo_in;
         src_off_ff <= src_off_in; dst_off_ff <= dst_off_in; src_ok_ff <= src_ok_in;
         bytes_ff <= bytes_in; chunks_ff <= chunks_in; due_ff <= due_in;
         state_ff <= state_in; hb_ff <= hb_in; unblk_ff <= unblk_in;
         pmode_ff <= pmode_in; phalt_ff <= phalt_in; busy_ff <= busy_in;
         conf_ff <= conf_in; pvaddr_ff <= pvaddr_in; poam_ff <= poam_in; own_ff <= own_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_TRANSFERRING |-> own_ff)
      else $error("transferring without bus ownership");
   assert property (@(posedge clock) disable iff (reset)
      state_ff <= ST_TRANSFERRING)
      else $error("state code out of range");
   assert property (@(posedge clock) disable iff (reset)
      (step && item.op == OP_READ) |=> $stable(state_ff))
      else $error("status read changed state");
endmodule

FILE: rtl/core/hblank_vram_dma_controller_core.sv
// top level of the hblank video-ram dma controller
//
// usage:
//   req_ channel carries one item: a register write, a status read or one
//   clock phase tick of the emulated machine (valid/ready)
//   rsp_ channel returns exactly one result item per request item
//   rsp_valid rises in the cycle after acceptance; throughput one item per
//   cycle without stalls, set by the single registered engine update
//   the engine state moves once per accepted item; the result sits in an
//   output register, and a new item is taken whenever that register is empty
//   or is being drained in the same cycle
//   when the receiver stalls, rsp_ payload holds and req_ready drops
//   reset (synchronous, active high) restores the register defaults:
//   source 0xd430, destination 0x99d0, chunk count 0xff, idle
module hblank_vram_dma_controller_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic [2:0]  req_reg_index,
   input  logic [7:0]  req_write_value,
   input  logic [1:0]  req_cycle_phase,
   input  logic [1:0]  req_ppu_mode,
   input  logic        req_cpu_halted,
   input  logic        req_cpu_stopped,
   input  logic        req_cpu_fetching,
   input  logic        req_double_speed,
   input  logic        req_oam_held_by_dma,
   input  logic [7:0]  req_source_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_read_value,
   output logic        rsp_src_read_en,
   output logic [15:0] rsp_src_address,
   output logic        rsp_vram_write_en,
   output logic [15:0] rsp_vram_address,
   output logic        rsp_oam_write_en,
   output logic [15:0] rsp_oam_address,
   output logic [7:0]  rsp_write_data,
   output logic        rsp_cpu_blocked,
   output logic        rsp_buses_held
);
   import hvdc_pkg::*;

   item_type   item;
   result_type res;
   result_type out_ff;
   logic       vld_ff;
   logic       step;

   assign item = '{op: req_op, reg_index: req_reg_index, write_value: req_write_value,
                   cycle_phase: req_cycle_phase, ppu_mode: req_ppu_mode,
                   cpu_halted: req_cpu_halted, cpu_stopped: req_cpu_stopped,
                   cpu_fetching: req_cpu_fetching, double_speed: req_double_speed,
                   oam_held_by_dma: req_oam_held_by_dma, source_data: req_source_data};

   // accept when the output register is free or draining
   assign req_ready = ~vld_ff | rsp_ready;
   assign step      = req_valid & req_ready;

   hvdc_engine u_engine (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .item  (item),
      .result(res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (req_ready) begin
         vld_ff <= req_valid;
      end
   end

   // payload register, no reset needed
   always_ff @(posedge clock) begin
      if (step) begin
         out_ff <= res;
      end
   end

   assign rsp_valid         = vld_ff;
   assign rsp_read_value    = out_ff.read_value;
   assign rsp_src_read_en   = out_ff.src_read_en;
   assign rsp_src_address   = out_ff.src_address;
   assign rsp_vram_write_en = out_ff.vram_write_en;
   assign rsp_vram_address  = out_ff.vram_address;
   assign rsp_oam_write_en  = out_ff.oam_write_en;
   assign rsp_oam_address   = out_ff.oam_address;
   assign rsp_write_data    = out_ff.write_data;
   assign rsp_cpu_blocked   = out_ff.cpu_blocked;
   assign rsp_buses_held    = out_ff.buses_held;

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result dropped while stalled");
   assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_valid)
      else $error("accepted item produced no result");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("accepted item while output full");
endmodule

FILE: tb/sv/tb_hblank_vram_dma_controller_core.sv
// testbench for the hblank video-ram dma controller core
`timescale 1ns / 100ps

module tb_hblank_vram_dma_controller_core;
   import hvdc_pkg::*;

   class dma_scoreboard;
      result_type expected_results[$];
      int unsigned mismatch_count;
      int unsigned unexpected_count;

      // dma engine shadow state
      logic [7:0]  src_hi, src_lo, dst_hi, dst_lo;
      logic [15:0] src_off, dst_off;
      logic [11:0] bytes_left;
      logic [7:0]  chunks_left;
      logic        chunk_due, hblank, prev_halted, busy, conflict, bus_own;
      logic [2:0]  xfer_state;
      logic [1:0]  unblock_cnt, prev_mode;
      logic [15:0] pend_vram;
      logic [7:0]  pend_oam_lo;

      function new();
         mismatch_count = 0;
         unexpected_count = 0;
         src_hi = SRC_HI_RST; src_lo = SRC_LO_RST;
         dst_hi = DST_HI_RST; dst_lo = DST_LO_RST;
         src_off = '0; dst_off = '0; bytes_left = '0; chunks_left = CHUNKS_RST;
         chunk_due = 0; hblank = 0; prev_halted = 0; busy = 0; conflict = 0;
         bus_own = 0; xfer_state = ST_NONE; unblock_cnt = '0; prev_mode = '0;
         pend_vram = '0; pend_oam_lo = '0;
      endfunction

      function logic [15:0] dst_sum();
         return (16'h8000 | {dst_hi, dst_lo}) + dst_off;
      endfunction

      function void advance_mode(item_type it);
         if (xfer_state == ST_PAUSED && prev_mode != 0 && it.ppu_mode == 0 && !prev_halted
               && !it.cpu_stopped)
            xfer_state = ST_REQUESTED;
         prev_mode = it.ppu_mode;
         prev_halted = it.cpu_halted;
      endfunction

      // note an accepted item and queue the result it causes
      function void note_item(item_type it);
         result_type r;
         logic [15:0] sa, da;
         r = '0;
         r.vram_address = 16'h8000;
         r.oam_address = 16'hFE00;
         if (it.op == OP_WRITE) begin
            case (it.reg_index)
               REG_SRC_HI: src_hi = it.write_value;
               REG_SRC_LO: begin
                  src_lo = it.write_value & 8'hF0;
                  src_off = '0;
               end
               REG_DST_HI: dst_hi = it.write_value;
               REG_DST_LO: begin
                  dst_lo = it.write_value & 8'hF0;
                  dst_off = '0;
               end
               REG_CTRL: begin
                  chunks_left = {1'b0, it.write_value[6:0]};
                  bytes_left = 12'(16 * (int'(it.write_value[6:0]) + 1));
                  if (xfer_state != ST_NONE) begin
                     if (!it.write_value[7]) xfer_state = ST_NONE;
                  end else if (it.write_value[7]) begin
                     hblank = 1;
                     xfer_state = (it.ppu_mode == 0) ? ST_REQUESTED : ST_PAUSED;
                  end else begin
                     hblank = 0;
                     xfer_state = ST_REQUESTED;
                  end
               end
               default: ;
            endcase
         end else if (it.op == OP_READ) begin
            r.read_value = {(xfer_state == ST_NONE), chunks_left[6:0]};
         end else if (it.op == OP_TICK) begin
            if (!it.cycle_phase[0]) begin
               if (xfer_state == ST_TRANSFERRING) begin
                  sa = {src_hi, src_lo} + src_off;
                  r.src_read_en = sa < 16'h8000 || (sa >= 16'hA000 && sa <= 16'hDFFF);
                  r.src_address = sa;
                  conflict = it.oam_held_by_dma && src_off[0];
                  pend_oam_lo = sa[7:0];
                  da = dst_sum();
                  pend_vram = 16'h8000 | {3'b0, da[12:0]};
               end
               advance_mode(it);
               if (xfer_state == ST_REQUESTED) xfer_state = ST_PENDING;
               else if (xfer_state == ST_PENDING) xfer_state = ST_READY;
            end else begin
               if (xfer_state == ST_TRANSFERRING) begin
                  r.vram_write_en = 1;
                  r.vram_address = pend_vram;
                  r.write_data = it.source_data;
                  if (conflict) begin
                     r.oam_write_en = 1;
                     r.oam_address = 16'hFE00 | pend_oam_lo;
                  end
                  src_off++;
                  dst_off++;
                  bytes_left = bytes_left - 12'd1;
                  if (bytes_left[3:0] == 0) begin
                     if (bytes_left == 0) xfer_state = ST_NONE;
                     else if (hblank) xfer_state = ST_PAUSED;
                     if (dst_sum() != 0) begin
                        if (hblank || chunks_left == 0) unblock_cnt = UNBLOCK_DELAY;
                     end else begin
                        // destination overflow ends the transfer
                        xfer_state = ST_NONE;
                        bytes_left = '0;
                        dst_hi = '0; dst_lo = '0; dst_off = '0;
                        unblock_cnt = UNBLOCK_DELAY;
                     end
                     if (xfer_state != ST_TRANSFERRING) bus_own = 0;
                     chunk_due = 1;
                  end
               end
               advance_mode(it);
               if (it.cycle_phase == 2'd3 || it.double_speed) begin
                  if (xfer_state == ST_READY) begin
                     if (it.cpu_fetching) begin
                        xfer_state = ST_TRANSFERRING;
                        busy = 1;
                        bus_own = 1;
                     end
                  end else if (chunk_due) begin
                     chunk_due = 0;
                     chunks_left--;
                  end else if (unblock_cnt != 0) begin
                     unblock_cnt--;
                     if (unblock_cnt == 0) busy = 0;
                  end
               end
            end
         end
         r.cpu_blocked = busy;
         r.buses_held = bus_own;
         expected_results.push_back(r);
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (expected_results.size() == 0) begin
            unexpected_count++;
            if (unexpected_count + mismatch_count <= 10)
               $display("unexpected result %h", got);
            return;
         end
         want = expected_results.pop_front();
         if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("mismatch: expected %h actual %h", want, got);
         end
      endfunction
   endclass

   logic clock, reset;
   logic req_valid, req_ready, rsp_valid, rsp_ready;
   item_type req_item;
   result_type rsp_item;
   dma_scoreboard board;
   bit stimulus_done;
   bit long_hold;
   logic [1:0] phase_ctr;

   hblank_vram_dma_controller_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_op(req_item.op), .req_reg_index(req_item.reg_index),
      .req_write_value(req_item.write_value), .req_cycle_phase(req_item.cycle_phase),
      .req_ppu_mode(req_item.ppu_mode), .req_cpu_halted(req_item.cpu_halted),
      .req_cpu_stopped(req_item.cpu_stopped), .req_cpu_fetching(req_item.cpu_fetching),
      .req_double_speed(req_item.double_speed),
      .req_oam_held_by_dma(req_item.oam_held_by_dma),
      .req_source_data(req_item.source_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_read_value(rsp_item.read_value), .rsp_src_read_en(rsp_item.src_read_en),
      .rsp_src_address(rsp_item.src_address), .rsp_vram_write_en(rsp_item.vram_write_en),
      .rsp_vram_address(rsp_item.vram_address), .rsp_oam_write_en(rsp_item.oam_write_en),
      .rsp_oam_address(rsp_item.oam_address), .rsp_write_data(rsp_item.write_data),
      .rsp_cpu_blocked(rsp_item.cpu_blocked), .rsp_buses_held(rsp_item.buses_held)
   );

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   // hard limit on run time
   initial begin
      #2000000;
      $display("FAIL");
      $finish;
   end

   // send one item, holding it until the handshake
   task automatic send_item(item_type it);
      req_valid <= 1'b1;
      req_item <= it;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_item(it);
   endtask

   task automatic idle_gap(int n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   function automatic item_type tick_item(logic [1:0] ph);
      item_type it;
      it = item_type'({$urandom, $urandom});
      it.op = OP_TICK;
      it.cycle_phase = ph;
      // ppu mode mostly steady so hblank edges come now and then
      it.ppu_mode = ($urandom_range(0, 15) == 0) ? 2'($urandom) : board.prev_mode;
      it.cpu_halted = ($urandom_range(0, 7) == 0);
      it.cpu_stopped = ($urandom_range(0, 7) == 0);
      it.cpu_fetching = ($urandom_range(0, 3) != 0);
      it.double_speed = ($urandom_range(0, 3) == 0);
      return it;
   endfunction

   function automatic item_type write_item(logic [2:0] idx, logic [7:0] v);
      item_type it;
      it = item_type'({$urandom, $urandom});
      it.op = OP_WRITE;
      it.reg_index = idx;
      it.write_value = v;
      return it;
   endfunction

   function automatic item_type next_tick();
      item_type it;
      it = tick_item(phase_ctr);
      phase_ctr++;
      return it;
   endfunction

   // program registers and start a transfer
   task automatic start_transfer(logic [7:0] shi, logic [7:0] slo, logic [7:0] dhi,
                                 logic [7:0] dlo, logic [7:0] ctrl);
      send_item(write_item(REG_SRC_HI, shi));
      send_item(write_item(REG_SRC_LO, slo));
      send_item(write_item(REG_DST_HI, dhi));
      send_item(write_item(REG_DST_LO, dlo));
      send_item(write_item(REG_CTRL, ctrl));
   endtask

   // receiver: random stall pattern plus one long hold
   initial begin
      rsp_ready = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (long_hold) rsp_ready <= 1'b0;
         else rsp_ready <= ($urandom_range(0, 9) < 7) || stimulus_done;
      end
   end

   initial begin
      @(negedge reset);
      repeat (600) @(posedge clock);
      long_hold = 1;
      repeat (80) @(posedge clock);
      long_hold = 0;
   end

   always @(posedge clock)
      if (!reset && rsp_valid && rsp_ready) board.check_result(rsp_item);

   initial begin
      item_type it;
      int sent, burst, wait_cnt;
      board = new();
      req_valid = 1'b0;
      req_item = '0;
      stimulus_done = 0;
      long_hold = 0;
      phase_ctr = '0;
      reset = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: status at reset, unused register and op, extremes
      it = next_tick(); it.op = OP_READ; send_item(it);
      send_item(write_item(3'd7, 8'hFF));
      send_item(write_item(3'd5, 8'h00));
      it = next_tick(); it.op = OP_NOP; send_item(it);
      // general transfer with destination overflow
      start_transfer(8'h00, 8'hFF, 8'hFF, 8'hF0, 8'h01);
      repeat (12) begin
         it = next_tick(); it.cpu_fetching = 1; it.oam_held_by_dma = 1; send_item(it);
      end
      // abort while active, then odd phase alone
      send_item(write_item(REG_CTRL, 8'h00));
      it = next_tick(); it.cycle_phase = 2'd1; send_item(it);
      start_transfer(8'hFF, 8'hF0, 8'h00, 8'h00, 8'hFF);
      it = next_tick(); it.op = OP_READ; send_item(it);
      send_item(write_item(REG_CTRL, 8'h7F));

      sent = 0;
      while (sent < 1950) begin
         burst = $urandom_range(1, 40);
         repeat (burst) begin
            if ($urandom_range(0, 99) < 3)
               start_transfer(8'($urandom), 8'($urandom), 8'($urandom),
                              8'($urandom), ($urandom_range(0, 3) == 0) ?
                              8'($urandom) : {1'($urandom), 7'($urandom_range(0, 3))});
            else if ($urandom_range(0, 99) < 3)
               send_item(write_item(3'($urandom), 8'($urandom)));
            else if ($urandom_range(0, 99) < 4) begin
               it = next_tick(); it.op = 2'($urandom); send_item(it);
            end else
               send_item(next_tick());
            sent++;
         end
         if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 6));
      end
      req_valid <= 1'b0;
      stimulus_done = 1;
      wait_cnt = 0;
      while (board.expected_results.size() != 0 && wait_cnt < 10000) begin
         @(posedge clock);
         wait_cnt++;
      end
      repeat (5) @(posedge clock);
      if (board.expected_results.size() == 0 && board.mismatch_count == 0
            && board.unexpected_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end
endmodule
